[src/u8u16_pkg.sv]
// Package: word types for the UTF-8 to UTF-16 decoder.
`default_nettype none

package u8u16_pkg;

  localparam int unsigned UnitW  = 16;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned PendW  = 2;

  localparam logic [UnitW-1:0] MaxUnitsRst = 16'hffff;

  // Byte masks for lead and continuation bytes
  localparam logic [ByteW-1:0] Lead2Mask = 8'h1f;
  localparam logic [ByteW-1:0] Lead3Mask = 8'h0f;
  localparam logic [ByteW-1:0] ContMask  = 8'h3f;

  localparam logic CmdData = 1'b0;
  localparam logic CmdEnd  = 1'b1;

  typedef struct packed {
    logic             command;
    logic [ByteW-1:0] in_byte;
  } in_item_t;

  typedef struct packed {
    logic [UnitW-1:0] code_unit;
    logic             is_terminator;
    logic [UnitW-1:0] unit_count;
  } out_item_t;

endpackage

`default_nettype wire

[src/u8u16_core.sv]
// Decoder core: sequence state and per-word decode logic.
`default_nettype none

module u8u16_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  u8u16_pkg::in_item_t   item_i,
  input  logic [15:0]           max_units_i,
  output logic                  res_valid_o,
  output u8u16_pkg::out_item_t  res_o
);
  import u8u16_pkg::*;

  logic [PendW-1:0] pend_q, pend_d;
  logic [UnitW-1:0] part_q, part_d;
  logic [UnitW-1:0] units_q, units_d;
  logic [UnitW-1:0] limit;
  logic [UnitW-1:0] merged;
  logic             full;

  // Capacity of 0 or 1 leaves room for the terminator only
  assign limit  = (max_units_i <= 16'd1) ? '0 : max_units_i - 16'd1;
  assign full   = (units_q >= limit);
  assign merged = {part_q[UnitW-7:0], item_i.in_byte[5:0] & ContMask[5:0]};

  always_comb begin
    pend_d      = pend_q;
    part_d      = part_q;
    units_d     = units_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (item_i.command == CmdEnd) begin
      res_valid_o         = 1'b1;
      res_o.is_terminator = 1'b1;
      res_o.unit_count    = units_q;
      pend_d              = '0;
      part_d              = '0;
      units_d             = '0;
    end else if (!full) begin
      if (pend_q != '0) begin
        pend_d = pend_q - 2'd1;
        part_d = merged;
        if (pend_q == 2'd1) begin
          // Last continuation: emit the assembled unit
          part_d           = '0;
          units_d          = units_q + 16'd1;
          res_valid_o      = 1'b1;
          res_o.code_unit  = merged;
          res_o.unit_count = units_q + 16'd1;
        end
      end else if (!item_i.in_byte[7]) begin
        units_d          = units_q + 16'd1;
        res_valid_o      = 1'b1;
        res_o.code_unit  = {8'h00, item_i.in_byte};
        res_o.unit_count = units_q + 16'd1;
      end else if (item_i.in_byte[7:5] == 3'b110) begin
        part_d = {8'h00, item_i.in_byte & Lead2Mask};
        pend_d = 2'd1;
      end else if (item_i.in_byte[7:4] == 4'b1110) begin
        part_d = {8'h00, item_i.in_byte & Lead3Mask};
        pend_d = 2'd2;
      end
      // Stray continuation and long lead: drop the byte
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= '0;
      part_q  <= '0;
      units_q <= '0;
    end else if (step_i) begin
      pend_q  <= pend_d;
      part_q  <= part_d;
      units_q <= units_d;
    end
  end

endmodule

`default_nettype wire

[src/utf8_to_utf16_decoder.sv]
// Top level: UTF-8 to UTF-16 (BMP) stream decoder with input and result registers.
// A held word is decoded combinationally and its result is loaded into the result register on advance.
// Throughput: one word per cycle while the result channel is not stalled; the single-pass
// decode between the input register and the result register sets this figure.
// Words that give no result (stray or pending bytes, capacity reached) still advance the decoder.
// Reset: asynchronous active low; clears all valids and sequence state, max_units to 65535.
`default_nettype none

module utf8_to_utf16_decoder (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Input channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  u8u16_pkg::in_item_t   in_item_i,
  // Result channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output u8u16_pkg::out_item_t  out_item_o,
  // Configuration: max_units
  input  logic                  cfg_we_i,
  input  logic [15:0]           cfg_wdata_i
);
  import u8u16_pkg::*;

  logic             in_valid_q;
  in_item_t         in_item_q;
  logic             out_valid_q;
  out_item_t        out_item_q;
  logic [UnitW-1:0] max_units_q;

  logic             out_free;
  logic             advance;
  logic             res_valid;
  out_item_t        res;

  // The result register can take a new word when empty or being drained
  assign out_free = !out_valid_q || !out_stall_i;
  // Move the held word through the decoder when the result side has room
  assign advance  = in_valid_q && out_free;
  // Stall the input only while a word is held and cannot advance
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_units_q <= MaxUnitsRst;
    end else if (cfg_we_i) begin
      max_units_q <= cfg_wdata_i;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_item_q <= in_item_i;
    end
  end

  u8u16_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .item_i      (in_item_q),
    .max_units_i (max_units_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Result register: load on advance, hold while stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && advance && res_valid) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef SYNTHESIS
  // Input stall only arises from a blocked result register
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a blocked result");

  // An accepted word is held in the input register next cycle
  a_accept_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_valid_q)
    else $error("accepted word lost");
`endif

endmodule

`default_nettype wire
